// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int TAG_W    = 32;
  localparam int PRIO_W   = 16;
  localparam int STAT_W   = 2;
  localparam int CNT_OUT_W = 5;

  // action codes
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              do_add;
    logic              do_get;
    logic [STAT_W-1:0] status;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } spq_sts_t;

endpackage

`default_nettype wire

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: decodes each beat and tracks the pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     in_action,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire spq_sts_t sts,
  output spq_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // input is held off only while a result waits and the sink stalls
  assign in_stall  = (state_r == ST_HOLD) && out_stall;
  assign out_valid = (state_r == ST_HOLD);
  assign accept    = in_valid && !in_stall;

  // command decode
  always_comb begin
    cmd.load   = accept;
    cmd.do_add = 1'b0;
    cmd.do_get = 1'b0;
    cmd.status = STAT_OK;
    if (in_action == ACT_ADD) begin
      if (sts.full) begin
        cmd.status = STAT_FULL;
      end else begin
        cmd.do_add = accept;
      end
    end else begin
      if (sts.empty) begin
        cmd.status = STAT_EMPTY;
      end else begin
        cmd.do_get = accept;
      end
    end
  end

  // result state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (accept) begin
          state_nxt = ST_HOLD;
        end else if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted entry cells, entry count and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire spq_cmd_t                 cmd,
  output spq_sts_t                      sts,
  input  wire logic [TAG_W-1:0]         in_tag,
  input  wire logic signed [PRIO_W-1:0] in_priority_req,
  output logic [STAT_W-1:0]             out_status,
  output logic [TAG_W-1:0]              out_tag,
  output logic [CNT_OUT_W-1:0]          out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [TAG_W-1:0]         tag_r  [DEPTH];
  logic signed [PRIO_W-1:0] prio_r [DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [DEPTH-1:0]         keep;

  logic [STAT_W-1:0]        status_r;
  logic [TAG_W-1:0]         otag_r;
  logic [CNT_OUT_W-1:0]     ocount_r;

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_W'(DEPTH));

  // count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_add) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_get) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // per-cell compare: held entries that stay ahead of the new one
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    assign keep[gi] = (count_r > CNT_W'(gi)) && (prio_r[gi] <= in_priority_req);

    if (gi == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.do_add && !keep[gi]) begin
          tag_r[gi]  <= in_tag;
          prio_r[gi] <= in_priority_req;
        end else if (cmd.do_get && (DEPTH > 1)) begin
          tag_r[gi]  <= tag_r[gi+1];
          prio_r[gi] <= prio_r[gi+1];
        end
      end
    end else if (gi == DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.do_add && !keep[gi]) begin
          if (keep[gi-1]) begin
            tag_r[gi]  <= in_tag;
            prio_r[gi] <= in_priority_req;
          end else begin
            tag_r[gi]  <= tag_r[gi-1];
            prio_r[gi] <= prio_r[gi-1];
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.do_add && !keep[gi]) begin
          if (keep[gi-1]) begin
            tag_r[gi]  <= in_tag;
            prio_r[gi] <= in_priority_req;
          end else begin
            tag_r[gi]  <= tag_r[gi-1];
            prio_r[gi] <= prio_r[gi-1];
          end
        end else if (cmd.do_get) begin
          tag_r[gi]  <= tag_r[gi+1];
          prio_r[gi] <= prio_r[gi+1];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.status;
      otag_r   <= cmd.do_get ? tag_r[0] : '0;
      ocount_r <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_status = status_r;
  assign out_tag    = otag_r;
  assign out_count  = ocount_r;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue, DEPTH entries kept in a row of compare-and-shift cells.
// The result is registered and valid in the cycle after the beat is accepted.
// Throughput: one add or get per cycle unless in_stall holds the input;
// every cell compares against the new priority in parallel to set its shift.
// Reset clears the entry count and the pending result; entry cells are not
// cleared and are read only below the entry count.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Top level: controller plus entry datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_action,
  input  wire logic [TAG_W-1:0]         in_tag,
  input  wire logic signed [PRIO_W-1:0] in_priority_req,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STAT_W-1:0]             out_status,
  output logic [TAG_W-1:0]              out_tag,
  output logic [CNT_OUT_W-1:0]          out_count
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  // beat control
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry storage and result
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_tag          (in_tag),
    .in_priority_req (in_priority_req),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_count       (out_count)
  );

endmodule

`default_nettype wire

// File: rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [STAT_W-1:0]        out_status,
  input wire logic [TAG_W-1:0]         out_tag,
  input wire logic [CNT_OUT_W-1:0]     out_count
);

  // failed operations carry no tag
  a_no_tag_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_tag == '0))
    else $error("tag on failed operation");

  // empty get reports zero entries
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  // full add reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (out_count == CNT_OUT_W'(DEPTH)))
    else $error("full status with wrong count");

  // accepted beat produces a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after accepted beat");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_tag) && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

`default_nettype wire
